// ===== rtl/ghb_pkg.sv =====
// Shared types, constants and helper functions for the grid hash bucket insert block.
// No dependencies; ghb_div, ghb_dp, ghb_ctrl and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ghb_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_AW     = 10;
  localparam int BUCKET_POOL = 1024;
  localparam int BKT_AW      = 10;
  localparam int ENTRY_POOL  = 4096;
  localparam int ENT_AW      = 12;
  localparam logic [31:0] PRIME = 32'hFFFF_FFFB;

  // Divider operand widths: 33-bit magnitude over a 46-bit divisor
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 46;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_CELL_WIDTH = 2'd0,
    REG_MIN_X      = 2'd1,
    REG_MIN_Y      = 2'd2,
    REG_TABLE_SIZE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_X   = 2'd0,
    DIV_Y   = 2'd1,
    DIV_MOD = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic [30:0] cell_width;
    logic [31:0] min_x;
    logic [31:0] min_y;
    logic [10:0] table_size;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cell_x;
    logic     cell_y;
    logic     dig_step;
    logic [3:0] dig_idx;
    logic     key_calc;
    logic     slot_latch;
    logic     slot_rd;
    logic     bkt_rd;
    logic     bkt_next;
    logic     commit;
    logic     hit;
    logic     clr_step;
    logic     out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic slot_valid;
    logic key_match;
    logic next_valid;
    logic clr_last;
    logic out_busy;
  } sts_t;

  // Powers of ten that fit under 2^31
  function automatic logic [31:0] pow10(input logic [3:0] k);
    logic [31:0] p;
    case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      4'd9: p = 32'd1000000000;
      default: p = 32'hFFFF_FFFF;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ghb_if.sv =====
// Valid/ready channel interfaces for the input request and the result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface ghb_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [19:0] point_index;
  logic [3:0]  level;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, req_type, point_index, level, coord_x, coord_y,
                  input ready);
  modport sink (input valid, req_type, point_index, level, coord_x, coord_y,
                output ready);
endinterface

interface ghb_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  slot;
  logic [31:0] key;
  logic        new_bucket;
  logic        pool_full;
  logic [10:0] bucket_count;
  logic [12:0] point_count;

  modport source (output valid, slot, key, new_bucket, pool_full, bucket_count,
                  point_count, input ready);
  modport sink (input valid, slot, key, new_bucket, pool_full, bucket_count,
                point_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/ghb_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ghb_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module ghb_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [ghb_pkg::DIV_NW-1:0] dividend,
  input  wire logic [ghb_pkg::DIV_DW-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [ghb_pkg::DIV_NW-1:0]      quot,
  output logic [ghb_pkg::DIV_DW-1:0]      rem
);
  localparam int CW = $clog2(ghb_pkg::DIV_NW + 1);

  logic [CW-1:0]              cnt_r;
  logic                       done_r;
  logic [ghb_pkg::DIV_NW-1:0] quot_r;
  logic [ghb_pkg::DIV_DW-1:0] rem_r;
  logic [ghb_pkg::DIV_DW-1:0] dsr_r;
  logic [ghb_pkg::DIV_DW:0]   trial;
  logic [ghb_pkg::DIV_DW:0]   diff;
  logic                       ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_r, quot_r[ghb_pkg::DIV_NW-1]};
    ge    = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(ghb_pkg::DIV_NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
    end else if (cnt_r != '0) begin
      quot_r <= {quot_r[ghb_pkg::DIV_NW-2:0], ge};
      rem_r  <= ge ? diff[ghb_pkg::DIV_DW-1:0] : trial[ghb_pkg::DIV_DW-1:0];
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/ghb_dp.sv =====
// Datapath: cell index, key and slot arithmetic, table memories, counters, result register.
// Depends on ghb_pkg and ghb_div; driven by commands from ghb_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module ghb_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ghb_pkg::cfg_t       cfg,
  input  wire ghb_pkg::cmd_t       cmd,
  output ghb_pkg::sts_t            sts,
  input  wire logic                in_req_type,
  input  wire logic [19:0]         in_point_index,
  input  wire logic [3:0]          in_level,
  input  wire logic signed [31:0]  in_coord_x,
  input  wire logic signed [31:0]  in_coord_y,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [9:0]               out_slot,
  output logic [31:0]              out_key,
  output logic                     out_new_bucket,
  output logic                     out_pool_full,
  output logic [10:0]              out_bucket_count,
  output logic [12:0]              out_point_count
);
  localparam int SAW = ghb_pkg::SLOT_AW;
  localparam int BAW = ghb_pkg::BKT_AW;
  localparam int EAW = ghb_pkg::ENT_AW;
  localparam int NW  = ghb_pkg::DIV_NW;
  localparam int DW  = ghb_pkg::DIV_DW;

  // Request registers
  logic              clr_req_r;
  logic [19:0]       pidx_r;
  logic [3:0]        level_r;
  logic [NW-1:0]     diff_x_r;
  logic [NW-1:0]     diff_y_r;

  // Arithmetic registers
  logic [31:0]       cellx_r;
  logic [31:0]       hv_r;
  logic [31:0]       key_r;
  logic [SAW-1:0]    slot_r;

  // Counters
  logic [BAW:0]      bkt_used_r;
  logic [EAW:0]      ent_used_r;
  logic [12:0]       hashed_r;
  logic [SAW-1:0]    clr_cnt_r;
  logic              nb_r;
  logic              full_r;

  // Memories: valid bit on top where a link may be absent
  logic [SAW:0]      slot_mem [ghb_pkg::TABLE_SLOTS];
  logic [31:0]       bkey_mem [ghb_pkg::BUCKET_POOL];
  logic [BAW:0]      bnext_mem [ghb_pkg::BUCKET_POOL];
  logic [19:0]       bfirst_mem [ghb_pkg::BUCKET_POOL];
  logic [EAW:0]      bent_mem [ghb_pkg::BUCKET_POOL];
  logic [19:0]       ept_mem [ghb_pkg::ENTRY_POOL];
  logic [EAW:0]      enext_mem [ghb_pkg::ENTRY_POOL];

  logic [SAW:0]      slot_rd_r;
  logic [31:0]       bkey_rd_r;
  logic [BAW:0]      bnext_rd_r;
  logic [EAW:0]      bent_rd_r;
  logic [BAW-1:0]    b_r;

  // Output register
  logic              out_valid_r;
  logic [9:0]        out_slot_r;
  logic [31:0]       out_key_r;
  logic              out_nb_r;
  logic              out_full_r;
  logic [10:0]       out_bc_r;
  logic [12:0]       out_pc_r;

  // Divider hookup
  logic              div_busy;
  logic              div_done;
  logic [NW-1:0]     div_quot;
  logic [DW-1:0]     div_rem;
  logic [NW-1:0]     div_nd;
  logic [DW-1:0]     div_dsr;

  logic [DW-1:0]     scale;
  logic [10:0]       ts_eff;
  logic [31:0]       sum;
  logic              miss_wr;
  logic              hit_wr;
  logic              slot_we;
  logic [SAW-1:0]    slot_wa;
  logic [SAW:0]      slot_wd;
  logic [BAW-1:0]    bkt_ra;
  logic [BAW-1:0]    nbk;
  logic [EAW-1:0]    ne;

  function automatic logic [NW-1:0] magn(input logic [NW-1:0] d);
    return d[NW-1] ? (~d + NW'(1)) : d;
  endfunction

  // Floor of a signed quotient, wrapped to 32 bits
  function automatic logic [31:0] floor_cell(input logic [NW-1:0] q, input logic [DW-1:0] r,
                                             input logic neg, input logic szero);
    logic [NW-1:0] qq;
    logic [31:0]   c;
    qq = q + NW'(neg && (r != '0));
    if (szero) begin
      c = '0;
    end else if (neg) begin
      c = ~qq[31:0] + 32'd1;
    end else begin
      c = q[31:0];
    end
    return c;
  endfunction

  // Cell width scaled by the level, effective table size, key sum
  always_comb begin
    scale = DW'({cfg.cell_width}) << level_r;
    if (cfg.table_size == '0) begin
      ts_eff = 11'd1;
    end else if (cfg.table_size > 11'(ghb_pkg::TABLE_SLOTS)) begin
      ts_eff = 11'(ghb_pkg::TABLE_SLOTS);
    end else begin
      ts_eff = cfg.table_size;
    end
    sum = hv_r + cellx_r;
  end

  // Divider operand select
  always_comb begin
    case (cmd.div_sel)
      ghb_pkg::DIV_X: begin
        div_nd  = magn(diff_x_r);
        div_dsr = scale;
      end
      ghb_pkg::DIV_Y: begin
        div_nd  = magn(diff_y_r);
        div_dsr = scale;
      end
      ghb_pkg::DIV_MOD: begin
        div_nd  = {1'b0, key_r};
        div_dsr = DW'(ts_eff);
      end
      default: begin
        div_nd  = '0;
        div_dsr = DW'(1);
      end
    endcase
  end

  ghb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_nd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Capture the request and run the arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clr_req_r <= in_req_type;
      pidx_r    <= in_point_index;
      level_r   <= in_level;
      diff_x_r  <= {in_coord_x[31], in_coord_x} - {cfg.min_x[31], cfg.min_x};
      diff_y_r  <= {in_coord_y[31], in_coord_y} - {cfg.min_y[31], cfg.min_y};
    end
    if (cmd.cell_x) begin
      cellx_r <= floor_cell(div_quot, div_rem, diff_x_r[NW-1], scale == '0);
    end
    if (cmd.cell_y) begin
      hv_r <= floor_cell(div_quot, div_rem, diff_y_r[NW-1], scale == '0);
    end
    // One decimal digit of the x cell per step
    if (cmd.dig_step && !cellx_r[31] && (cellx_r >= ghb_pkg::pow10(cmd.dig_idx))) begin
      hv_r <= (hv_r << 3) + (hv_r << 1);
    end
    if (cmd.key_calc) begin
      key_r <= (sum >= ghb_pkg::PRIME) ? (sum - ghb_pkg::PRIME) : sum;
    end
    if (cmd.slot_latch) begin
      slot_r <= div_rem[SAW-1:0];
    end
  end

  // Pool checks and write enables
  always_comb begin
    nbk     = bkt_used_r[BAW-1:0];
    ne      = ent_used_r[EAW-1:0];
    miss_wr = cmd.commit && !cmd.hit && (bkt_used_r < (BAW+1)'(ghb_pkg::BUCKET_POOL));
    hit_wr  = cmd.commit && cmd.hit && (ent_used_r < (EAW+1)'(ghb_pkg::ENTRY_POOL));
    slot_we = cmd.clr_step || miss_wr;
    slot_wa = cmd.clr_step ? clr_cnt_r : slot_r;
    slot_wd = cmd.clr_step ? '0 : {1'b1, nbk};
    bkt_ra  = cmd.bkt_next ? bnext_rd_r[BAW-1:0] : slot_rd_r[BAW-1:0];
  end

  // Slot head memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (cmd.slot_rd) begin
      slot_rd_r <= slot_mem[slot_r];
    end
  end

  // Bucket memories
  always_ff @(posedge clk) begin
    if (miss_wr) begin
      bkey_mem[nbk]   <= key_r;
      bnext_mem[nbk]  <= slot_rd_r;
      bfirst_mem[nbk] <= pidx_r;
    end
    if (miss_wr) begin
      bent_mem[nbk] <= '0;
    end else if (hit_wr) begin
      bent_mem[b_r] <= {1'b1, ne};
    end
    if (cmd.bkt_rd) begin
      b_r        <= bkt_ra;
      bkey_rd_r  <= bkey_mem[bkt_ra];
      bnext_rd_r <= bnext_mem[bkt_ra];
      bent_rd_r  <= bent_mem[bkt_ra];
    end
  end

  // Entry memories
  always_ff @(posedge clk) begin
    if (hit_wr) begin
      ept_mem[ne]   <= pidx_r;
      enext_mem[ne] <= bent_rd_r;
    end
  end

  // Counters, clearing pass and commit flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_used_r <= '0;
      ent_used_r <= '0;
      hashed_r   <= '0;
      clr_cnt_r  <= '0;
      nb_r       <= 1'b0;
      full_r     <= 1'b0;
    end else begin
      if (cmd.load && in_req_type) begin
        bkt_used_r <= '0;
        ent_used_r <= '0;
        hashed_r   <= '0;
      end else if (miss_wr) begin
        bkt_used_r <= bkt_used_r + (BAW+1)'(1);
        hashed_r   <= hashed_r + 13'd1;
      end else if (hit_wr) begin
        ent_used_r <= ent_used_r + (EAW+1)'(1);
        hashed_r   <= hashed_r + 13'd1;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + SAW'(1);
      end
      if (cmd.commit) begin
        nb_r   <= miss_wr;
        full_r <= !(miss_wr || hit_wr);
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot_r <= clr_req_r ? '0 : 10'(slot_r);
      out_key_r  <= clr_req_r ? '0 : key_r;
      out_nb_r   <= clr_req_r ? 1'b0 : nb_r;
      out_full_r <= clr_req_r ? 1'b0 : full_r;
      out_bc_r   <= 11'(bkt_used_r);
      out_pc_r   <= hashed_r;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.div_done   = div_done;
    sts.slot_valid = slot_rd_r[SAW];
    sts.key_match  = (bkey_rd_r == key_r);
    sts.next_valid = bnext_rd_r[BAW];
    sts.clr_last   = (clr_cnt_r == SAW'(ghb_pkg::TABLE_SLOTS - 1));
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_slot         = out_slot_r;
  assign out_key          = out_key_r;
  assign out_new_bucket   = out_nb_r;
  assign out_pool_full    = out_full_r;
  assign out_bucket_count = out_bc_r;
  assign out_point_count  = out_pc_r;

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    hashed_r == (13'(bkt_used_r) + 13'(ent_used_r)))
    else $error("point count differs from buckets plus entries");

  a_bkt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bkt_used_r <= (BAW+1)'(ghb_pkg::BUCKET_POOL))
    else $error("bucket count beyond pool");

  a_commit_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (miss_wr || hit_wr) |=> hashed_r == $past(hashed_r) + 13'd1)
    else $error("insert did not advance point count");
`endif

endmodule
`default_nettype wire

// ===== rtl/ghb_ctrl.sv =====
// Controller: sequences one transaction through the datapath by commands.
// Depends on ghb_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module ghb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_req_type,
  output logic               in_ready,
  input  wire ghb_pkg::sts_t sts,
  output ghb_pkg::cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_DIG,
    S_KEY, S_MD_GO, S_MD_WAIT, S_SRD, S_SCHK, S_BCHK, S_COMMIT, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       hit_r, hit_nxt;
  logic       take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_ready && in_valid;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    hit_nxt     = hit_r;
    cmd         = '0;
    cmd.div_sel = ghb_pkg::DIV_X;
    cmd.dig_idx = cnt_r;
    cmd.hit     = hit_r;
    case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          cmd.load  = 1'b1;
          state_nxt = in_req_type ? S_CLR : S_DX_GO;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_OUT;
      end
      S_DX_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (sts.div_done) begin
          cmd.cell_x = 1'b1;
          state_nxt  = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ghb_pkg::DIV_Y;
        state_nxt     = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        cmd.div_sel = ghb_pkg::DIV_Y;
        if (sts.div_done) begin
          cmd.cell_y = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_DIG;
        end
      end
      S_DIG: begin
        cmd.dig_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'd9) state_nxt = S_KEY;
      end
      S_KEY: begin
        cmd.key_calc = 1'b1;
        state_nxt    = S_MD_GO;
      end
      S_MD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ghb_pkg::DIV_MOD;
        state_nxt     = S_MD_WAIT;
      end
      S_MD_WAIT: begin
        cmd.div_sel = ghb_pkg::DIV_MOD;
        if (sts.div_done) begin
          cmd.slot_latch = 1'b1;
          state_nxt      = S_SRD;
        end
      end
      S_SRD: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = S_SCHK;
      end
      // Empty slot is a miss; else fetch the chain head
      S_SCHK: begin
        if (sts.slot_valid) begin
          cmd.bkt_rd = 1'b1;
          state_nxt  = S_BCHK;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_COMMIT;
        end
      end
      // Walk the chain one bucket per cycle
      S_BCHK: begin
        if (sts.key_match) begin
          hit_nxt   = 1'b1;
          state_nxt = S_COMMIT;
        end else if (sts.next_valid) begin
          cmd.bkt_rd   = 1'b1;
          cmd.bkt_next = 1'b1;
        end else begin
          hit_nxt   = 1'b0;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hit_r   <= hit_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !cmd.div_start)
    else $error("back to back divider starts");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_OUT)
    else $error("commit not followed by result stage");

  a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR && sts.clr_last) |=> state_r == S_OUT)
    else $error("clear pass did not end in result stage");
`endif

endmodule
`default_nettype wire

// ===== rtl/grid_hash_bucket_insert.sv =====
// Top level: configuration registers, controller and datapath of the grid hash insert.
// Depends on ghb_pkg, ghb_if, ghb_ctrl and ghb_dp.
//
//  channel  | direction | handshake                  | payload
//  in_ch    | input     | valid/ready                | req_type point_index level coord_x coord_y
//  out_ch   | output    | valid/ready                | slot key new_bucket pool_full counts
//  cfg_*    | input     | APB write, pready tied high | cell_width min_x min_y table_size
//
// An insert runs the shared bit-serial divider three times, for the x cell, the y
// cell and the slot modulo, then walks the chain of its slot, if any, bucket by
// bucket until a key matches or the chain ends.
// A clear empties all 1024 slot heads, one slot-head memory entry per cycle.
// After reset the same clearing pass runs before in_ch.ready rises.
// A finished result waits in the output register; the next transaction is
// taken meanwhile and stalls only when its own result is ready.
`timescale 1ns / 1ps
`default_nettype none
module grid_hash_bucket_insert (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ghb_in_if.sink           in_ch,
  ghb_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  ghb_pkg::cfg_t   cfg_r;
  ghb_pkg::cmd_t   cmd;
  ghb_pkg::sts_t   sts;
  ghb_pkg::reg_idx_t ridx;
  logic            cfg_wr;

  assign ridx       = ghb_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_width <= 31'd65536;
      cfg_r.min_x      <= '0;
      cfg_r.min_y      <= '0;
      cfg_r.table_size <= 11'd1024;
    end else if (cfg_wr) begin
      case (ridx)
        ghb_pkg::REG_CELL_WIDTH: cfg_r.cell_width <= cfg_pwdata[30:0];
        ghb_pkg::REG_MIN_X:      cfg_r.min_x      <= cfg_pwdata;
        ghb_pkg::REG_MIN_Y:      cfg_r.min_y      <= cfg_pwdata;
        ghb_pkg::REG_TABLE_SIZE: cfg_r.table_size <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (ridx)
      ghb_pkg::REG_CELL_WIDTH: cfg_prdata = {1'b0, cfg_r.cell_width};
      ghb_pkg::REG_MIN_X:      cfg_prdata = cfg_r.min_x;
      ghb_pkg::REG_MIN_Y:      cfg_prdata = cfg_r.min_y;
      ghb_pkg::REG_TABLE_SIZE: cfg_prdata = {21'b0, cfg_r.table_size};
      default:                 cfg_prdata = '0;
    endcase
  end

  ghb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  ghb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_ch.req_type),
    .in_point_index   (in_ch.point_index),
    .in_level         (in_ch.level),
    .in_coord_x       (in_ch.coord_x),
    .in_coord_y       (in_ch.coord_y),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_slot         (out_ch.slot),
    .out_key          (out_ch.key),
    .out_new_bucket   (out_ch.new_bucket),
    .out_pool_full    (out_ch.pool_full),
    .out_bucket_count (out_ch.bucket_count),
    .out_point_count  (out_ch.point_count)
  );

endmodule
`default_nettype wire
